// ===== rtl/llra_pkg.sv =====
// ----------------------------------------------------------------------------
// llra_pkg
// Shared types and constants for the least loaded row assign block.
// ----------------------------------------------------------------------------
package llra_pkg;

   localparam int WIDTH_W    = 12;
   localparam int FILL_W     = 16;
   localparam int ROW_IDX_W  = 6;
   localparam int ROW_CNT_W  = 7;
   localparam int GAP_W      = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP       = 2'd1;

   localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RST = 7'd1;
   localparam logic [GAP_W-1:0]     GAP_RST       = 10'd0;

   localparam logic [FILL_W-1:0] FILL_MAX = 16'hFFFF;

   typedef struct packed {
      logic take_item;
      logic rd_min;
      logic rd_max;
      logic commit;
      logic clear_wr;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic item_last;
      logic rsp_busy;
   } sts_type;

endpackage

// ===== rtl/llra_ctrl.sv =====
// ----------------------------------------------------------------------------
// llra_ctrl
// Sequencer: clear sweep, minimum scan, commit, widest-fill sweep, result.
// ----------------------------------------------------------------------------
module llra_ctrl #(
   parameter int MAX_ROWS = 64,
   localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  llra_pkg::sts_type   sts,
   input  logic [AW-1:0]       n_last,
   output llra_pkg::cmd_type   cmd,
   output logic [AW-1:0]       addr
);

   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ROWS - 1);

   localparam logic [2:0] S_CLEAR    = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_SCAN     = 3'd2;
   localparam logic [2:0] S_SCAN_END = 3'd3;
   localparam logic [2:0] S_COMMIT   = 3'd4;
   localparam logic [2:0] S_DRAIN    = 3'd5;
   localparam logic [2:0] S_OUT      = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic          maxm_ff, maxm_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      maxm_in   = maxm_ff;
      cmd       = '0;
      req_ready = 1'b0;
      addr      = cnt_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cmd.rd_max   = maxm_ff && (cnt_ff <= n_last);
            if (cnt_ff == LAST_ADDR) begin
               cnt_in   = '0;
               state_in = maxm_ff ? S_DRAIN : S_IDLE;
            end else begin
               cnt_in = AW'(cnt_ff + 1'b1);
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_item = 1'b1;
               cnt_in        = '0;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.rd_min = 1'b1;
            if (cnt_ff == n_last) begin
               cnt_in   = '0;
               state_in = S_SCAN_END;
            end else begin
               cnt_in = AW'(cnt_ff + 1'b1);
            end
         end
         S_SCAN_END: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            if (sts.item_last) begin
               maxm_in  = 1'b1;
               cnt_in   = '0;
               state_in = S_CLEAR;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DRAIN: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!sts.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               maxm_in      = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
         maxm_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         maxm_ff  <= maxm_in;
      end
   end

endmodule

// ===== rtl/llra_dp.sv =====
// ----------------------------------------------------------------------------
// llra_dp
// Datapath: registers, row fill memory, min/max accumulators, result register.
// ----------------------------------------------------------------------------
module llra_dp #(
   parameter int MAX_ROWS = 64,
   localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [llra_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [llra_pkg::CSR_DATA_W-1:0]        csr_data,
   input  logic [llra_pkg::WIDTH_W-1:0]           req_item_width,
   input  logic                                   req_pass_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [llra_pkg::ROW_IDX_W-1:0]         rsp_row_index,
   output logic [llra_pkg::FILL_W-1:0]            rsp_start_pos,
   output logic [llra_pkg::FILL_W-1:0]            rsp_widest_fill,
   output logic                                   rsp_fill_saturated,
   output logic                                   rsp_pass_done,
   input  llra_pkg::cmd_type                      cmd,
   input  logic [AW-1:0]                          addr,
   output llra_pkg::sts_type                      sts,
   output logic [AW-1:0]                          n_last
);

   localparam int FW = llra_pkg::FILL_W;

   logic [llra_pkg::ROW_CNT_W-1:0] row_count_ff;
   logic [llra_pkg::GAP_W-1:0]     gap_ff, pass_gap_ff;
   logic                           fresh_ff, sat_ff;
   logic [llra_pkg::WIDTH_W-1:0]   width_ff;
   logic                           last_ff;

   logic [FW:0]    mem [MAX_ROWS];
   logic [FW:0]    rd_data_ff;
   logic [AW-1:0]  rd_idx_ff;
   logic           rd_min_ff, rd_max_ff;
   logic [FW-1:0]  min_ff, max_ff;
   logic [AW-1:0]  best_ff;

   logic [llra_pkg::ROW_IDX_W-1:0] row_index_ff;
   logic [FW-1:0]  start_ff, widest_ff;
   logic           osat_ff, done_ff, rsp_valid_ff;

   logic [FW-1:0]  rd_fill;
   logic [FW:0]    sum;
   logic [FW-1:0]  new_fill;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [FW:0]    wr_data;
   logic [31:0]    rc_ext;

   assign csr_ready = 1'b1;

   always_comb begin
      rc_ext = 32'(row_count_ff);
      if (rc_ext == 32'd0) begin
         n_last = '0;
      end else if (rc_ext > 32'(MAX_ROWS)) begin
         n_last = AW'(MAX_ROWS - 1);
      end else begin
         n_last = AW'(rc_ext - 32'd1);
      end
   end

   assign rd_fill  = rd_data_ff[FW] ? rd_data_ff[FW-1:0] : FW'(pass_gap_ff);
   assign sum      = (FW+1)'(min_ff) + (FW+1)'(width_ff) + (FW+1)'(gap_ff);
   assign new_fill = sum[FW] ? llra_pkg::FILL_MAX : sum[FW-1:0];

   always_comb begin
      wr_en   = cmd.commit || cmd.clear_wr;
      wr_addr = cmd.commit ? best_ff : addr;
      wr_data = cmd.commit ? {1'b1, new_fill} : '0;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_min || cmd.rd_max) begin
         rd_data_ff <= mem[addr];
      end
      rd_idx_ff <= addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= llra_pkg::ROW_COUNT_RST;
         gap_ff       <= llra_pkg::GAP_RST;
      end else if (csr_valid) begin
         case (csr_index)
            llra_pkg::CSR_ROW_COUNT: row_count_ff <= csr_data[llra_pkg::ROW_CNT_W-1:0];
            llra_pkg::CSR_GAP:       gap_ff       <= csr_data[llra_pkg::GAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff     <= 1'b1;
         sat_ff       <= 1'b0;
         rd_min_ff    <= 1'b0;
         rd_max_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_min_ff <= cmd.rd_min;
         rd_max_ff <= cmd.rd_max;
         if (cmd.take_item && fresh_ff) begin
            fresh_ff <= 1'b0;
            sat_ff   <= 1'b0;
         end else if (cmd.commit) begin
            sat_ff <= sat_ff | sum[FW];
         end else if (cmd.load_rsp && last_ff) begin
            fresh_ff <= 1'b1;
            sat_ff   <= 1'b0;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         width_ff <= req_item_width;
         last_ff  <= req_pass_last;
         min_ff   <= llra_pkg::FILL_MAX;
         best_ff  <= '0;
         max_ff   <= '0;
         if (fresh_ff) begin
            pass_gap_ff <= gap_ff;
         end
      end else begin
         if (rd_min_ff && (rd_fill < min_ff)) begin
            min_ff  <= rd_fill;
            best_ff <= rd_idx_ff;
         end
         if (rd_max_ff && (rd_fill > max_ff)) begin
            max_ff <= rd_fill;
         end
      end
      if (cmd.load_rsp) begin
         row_index_ff <= llra_pkg::ROW_IDX_W'(best_ff);
         start_ff     <= min_ff;
         widest_ff    <= last_ff ? max_ff : '0;
         osat_ff      <= sat_ff;
         done_ff      <= last_ff;
      end
   end

   assign sts.item_last = last_ff;
   assign sts.rsp_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_row_index      = row_index_ff;
   assign rsp_start_pos      = start_ff;
   assign rsp_widest_fill    = widest_ff;
   assign rsp_fill_saturated = osat_ff;
   assign rsp_pass_done      = done_ff;

endmodule

// ===== rtl/least_loaded_row_assign_core.sv =====
// ----------------------------------------------------------------------------
// least_loaded_row_assign_core
// Greedy least-loaded row placement of item widths, one pass at a time.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : register writes, csr_index 0 = row_count, 1 = gap; always ready.
//            Write only while the block is idle.
//   req_*  : one beat per item (width, pass_last), taken one at a time.
//   rsp_*  : one beat per item; held in an output register until taken.
// Scan: after acceptance, the row fill memory is scanned one row a cycle
//   over the N active rows, N being the active row count, for the least
//   filled row. The last item of a pass adds a widest-fill sweep over all
//   MAX_ROWS rows, which also marks every row stale for the next pass.
// Flow: the next item is accepted only after the previous one is loaded.
// Reset: clears control state and runs a sweep over every row of the fill
//   memory; req_ready stays low until it is done.
// Stall: a held result does not block acceptance or the scan of the next
//   item; that item waits for the output register before it is loaded.
// ----------------------------------------------------------------------------
module least_loaded_row_assign_core #(
   parameter int MAX_ROWS = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [llra_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [llra_pkg::CSR_DATA_W-1:0]        csr_data,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [llra_pkg::WIDTH_W-1:0]           req_item_width,
   input  logic                                   req_pass_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [llra_pkg::ROW_IDX_W-1:0]         rsp_row_index,
   output logic [llra_pkg::FILL_W-1:0]            rsp_start_pos,
   output logic [llra_pkg::FILL_W-1:0]            rsp_widest_fill,
   output logic                                   rsp_fill_saturated,
   output logic                                   rsp_pass_done
);

   localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   llra_pkg::cmd_type cmd;
   llra_pkg::sts_type sts;
   logic [AW-1:0]     addr;
   logic [AW-1:0]     n_last;

   llra_ctrl #(
      .MAX_ROWS (MAX_ROWS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .n_last    (n_last),
      .cmd       (cmd),
      .addr      (addr)
   );

   llra_dp #(
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_item_width     (req_item_width),
      .req_pass_last      (req_pass_last),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_row_index      (rsp_row_index),
      .rsp_start_pos      (rsp_start_pos),
      .rsp_widest_fill    (rsp_widest_fill),
      .rsp_fill_saturated (rsp_fill_saturated),
      .rsp_pass_done      (rsp_pass_done),
      .cmd                (cmd),
      .addr               (addr),
      .sts                (sts),
      .n_last             (n_last)
   );

endmodule

// ===== rtl/llra_check.sv =====
// ----------------------------------------------------------------------------
// llra_check
// Port-level checks for least_loaded_row_assign_core.
// ----------------------------------------------------------------------------
module llra_check (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic [llra_pkg::ROW_IDX_W-1:0]         rsp_row_index,
   input logic [llra_pkg::FILL_W-1:0]            rsp_start_pos,
   input logic [llra_pkg::FILL_W-1:0]            rsp_widest_fill,
   input logic                                   rsp_fill_saturated,
   input logic                                   rsp_pass_done
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_index)
         && $stable(rsp_start_pos) && $stable(rsp_widest_fill)
         && $stable(rsp_fill_saturated) && $stable(rsp_pass_done))
      else $error("rsp beat changed while stalled");

   a_widest_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pass_done |-> rsp_widest_fill == '0)
      else $error("widest fill set outside pass end");

   a_widest_ge_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pass_done |-> rsp_widest_fill >= rsp_start_pos)
      else $error("widest fill below start position");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second beat accepted during work");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("activity right after reset");

endmodule

bind least_loaded_row_assign_core llra_check u_llra_check (.*);
